@@ design/apss_pkg.sv @@
`timescale 1ns / 1ps

package apss_pkg;

	// Default geometry of the page atlas.
	localparam int PAGE_PIXELS           = 120;
	localparam int SHARD_SIDE_PAGES      = 512;
	localparam int LEVEL_COUNT           = 10;
	localparam int PAGES_PER_AXIS_BUDGET = 2;

	// Field widths of the input and result beats.
	localparam int RECT_W   = 18;
	localparam int LVL_W    = 4;
	localparam int COL_W    = 11;
	localparam int SHARD_W  = 5;
	localparam int CELL_W   = 19;
	localparam int CROPXY_W = 7;
	localparam int CROPWH_W = 8;

	// The right edge x + w - 1 of an 18-bit rectangle always fits in 19 bits.
	localparam int DIV_W     = RECT_W + 1;
	localparam int DIV_LANES = 4;

	// Lane order within the divider.
	localparam int LANE_X0 = 0;
	localparam int LANE_Y0 = 1;
	localparam int LANE_X1 = 2;
	localparam int LANE_Y1 = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEARCH,
		ST_CROP,
		ST_CLIP,
		ST_PAGE,
		ST_LOAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               in_grid;
		logic [SHARD_W-1:0] shard;
		logic [CELL_W-1:0]  cell_idx;
	} page_res_t;

endpackage

@@ design/apss_div.sv @@
`timescale 1ns / 1ps

// Division of four operands by the constant page size. One shared multiplier
// takes the operands in turn, one per cycle, and multiplies by a reciprocal
// scaled so that the truncated product is the exact quotient for any 19-bit
// operand.
module apss_div #(
	parameter int PAGE_PIXELS = apss_pkg::PAGE_PIXELS
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	input  logic [apss_pkg::DIV_LANES-1:0][apss_pkg::DIV_W-1:0]   opnd,
	output logic                                                  done,
	output logic [apss_pkg::DIV_LANES-1:0][apss_pkg::DIV_W-1:0]   quot
);

	localparam int SH  = apss_pkg::DIV_W + $clog2(PAGE_PIXELS);
	localparam int RCW = apss_pkg::DIV_W + 2;
	localparam int PW  = apss_pkg::DIV_W + RCW;
	localparam int LW  = $clog2(apss_pkg::DIV_LANES);
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(PAGE_PIXELS) - 64'd1) / 64'(PAGE_PIXELS);
	localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);

	logic                                                busy_q;
	logic                                                done_q;
	logic [LW-1:0]                                       lane_q;
	logic [apss_pkg::DIV_LANES-1:0][apss_pkg::DIV_W-1:0] num_q;
	logic [apss_pkg::DIV_LANES-1:0][apss_pkg::DIV_W-1:0] quot_q;
	logic [PW-1:0]                                       prod;

	assign prod = PW'(num_q[lane_q]) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			lane_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				lane_q <= '0;
			end else if (busy_q) begin
				lane_q <= lane_q + LW'(1);
				if (lane_q == LW'(apss_pkg::DIV_LANES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= opnd;
		end else if (busy_q) begin
			quot_q[lane_q] <= apss_pkg::DIV_W'(prod >> SH);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ design/apss_page.sv @@
`timescale 1ns / 1ps

// Shard and cell lookup for one page. The page coordinate is split into shard
// and offset before the register; the cell index is formed behind it.
module apss_page #(
	parameter int AXW = 10
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [apss_pkg::DIV_W-1:0]    pc,
	input  logic [apss_pkg::DIV_W-1:0]    pr,
	input  logic [AXW-1:0]                axis,
	input  logic [apss_pkg::CELL_W-1:0]   base,
	output apss_pkg::page_res_t           res
);

	localparam int MXW = AXW + 2;

	logic [MXW-1:0]                     m1;
	logic [MXW-1:0]                     m2;
	logic [MXW-1:0]                     m3;
	logic [MXW-1:0]                     m4;
	logic [1:0][apss_pkg::DIV_W-1:0]    v;
	logic [1:0][1:0]                    q;
	logic [1:0][AXW-1:0]                r;
	logic [1:0][MXW-1:0]                sub;
	logic                               in_grid;
	logic                               inside_s1;
	logic [1:0]                         qc_s1;
	logic [1:0]                         qr_s1;
	logic [AXW-1:0]                     rc_s1;
	logic [AXW-1:0]                     rr_s1;
	logic [2*AXW-1:0]                   prod;
	logic [apss_pkg::CELL_W-1:0]        cell_sum;

	assign m1 = MXW'(axis);
	assign m2 = m1 << 1;
	assign m3 = m1 + m2;
	assign m4 = m1 << 2;
	assign v[0] = pc;
	assign v[1] = pr;

	// Inside the grid the coordinate is below four shard sides, so three
	// compares give the shard quotient.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (v[k] >= apss_pkg::DIV_W'(m3)) begin
				q[k]   = 2'd3;
				sub[k] = m3;
			end else if (v[k] >= apss_pkg::DIV_W'(m2)) begin
				q[k]   = 2'd2;
				sub[k] = m2;
			end else if (v[k] >= apss_pkg::DIV_W'(m1)) begin
				q[k]   = 2'd1;
				sub[k] = m1;
			end else begin
				q[k]   = 2'd0;
				sub[k] = '0;
			end
			r[k] = AXW'(v[k] - apss_pkg::DIV_W'(sub[k]));
		end
	end

	assign in_grid = (axis != '0) && (pc < apss_pkg::DIV_W'(m4)) &&
		(pr < apss_pkg::DIV_W'(m4));

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s1 <= in_grid;
			qc_s1     <= q[0];
			qr_s1     <= q[1];
			rc_s1     <= r[0];
			rr_s1     <= r[1];
		end
	end

	assign prod     = (2*AXW)'(rr_s1) * (2*AXW)'(axis);
	assign cell_sum = base + apss_pkg::CELL_W'(prod) + apss_pkg::CELL_W'(rc_s1);

	assign res.in_grid  = inside_s1;
	assign res.shard    = inside_s1 ? apss_pkg::SHARD_W'({qr_s1, qc_s1}) + apss_pkg::SHARD_W'(1)
		: '0;
	assign res.cell_idx = inside_s1 ? cell_sum : '0;

endmodule

@@ design/atlas_page_span_select_unit.sv @@
`timescale 1ns / 1ps

// Atlas page span selector.
// One rectangle (rect_x, rect_y, rect_w, rect_h) is taken per input beat on
// in_valid/in_ready. The block picks the finest mip level at which the
// rectangle spans at most the page budget on each axis and sends one result
// beat per page of that span, row-major, on out_valid/out_ready, with last set
// on the final beat. If no level fits, a single beat with status 1 is sent.
// The four page quotients come from one shared reciprocal multiplier, one
// operand at a time; the level search then shifts them one level per cycle.
// Then the crop offset and clipped crop size are formed, and each page passes
// through the shard lookup and a result load before its beat, the next page
// once the previous beat is taken. A no-fit result goes straight to output.
// One rectangle is processed at a time: in_ready is high only while idle,
// and returns the cycle after the last result beat is taken.
// A stalled receiver simply holds the block with the result beat steady.
// Reset returns the block to idle with no result pending; no memory is
// cleared.
module atlas_page_span_select_unit #(
	parameter int PAGE_PIXELS           = apss_pkg::PAGE_PIXELS,
	parameter int SHARD_SIDE_PAGES      = apss_pkg::SHARD_SIDE_PAGES,
	parameter int LEVEL_COUNT           = apss_pkg::LEVEL_COUNT,
	parameter int PAGES_PER_AXIS_BUDGET = apss_pkg::PAGES_PER_AXIS_BUDGET
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [apss_pkg::RECT_W-1:0]     rect_x,
	input  logic [apss_pkg::RECT_W-1:0]     rect_y,
	input  logic [apss_pkg::RECT_W-1:0]     rect_w,
	input  logic [apss_pkg::RECT_W-1:0]     rect_h,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output logic [apss_pkg::LVL_W-1:0]      mip_level,
	output logic [apss_pkg::COL_W-1:0]      page_col,
	output logic [apss_pkg::COL_W-1:0]      page_row,
	output logic [apss_pkg::SHARD_W-1:0]    shard_num,
	output logic [apss_pkg::CELL_W-1:0]     cell_index,
	output logic                            page_inside,
	output logic [apss_pkg::CROPXY_W-1:0]   crop_x,
	output logic [apss_pkg::CROPXY_W-1:0]   crop_y,
	output logic [apss_pkg::CROPWH_W-1:0]   crop_w,
	output logic [apss_pkg::CROPWH_W-1:0]   crop_h,
	output logic                            last
);

	localparam int RW   = apss_pkg::RECT_W;
	localparam int DW   = apss_pkg::DIV_W;
	localparam int CLW  = apss_pkg::CELL_W;
	localparam int PPW  = $clog2(PAGE_PIXELS + 1);
	localparam int SXW  = $clog2(PAGE_PIXELS);
	localparam int NW   = $clog2(PAGES_PER_AXIS_BUDGET + 1);
	localparam int AXW  = $clog2(SHARD_SIDE_PAGES + 1);
	localparam int MW   = DW + PPW;
	localparam int CWW  = NW + PPW;
	localparam logic [apss_pkg::LVL_W-1:0] LAST_LVL = apss_pkg::LVL_W'(LEVEL_COUNT - 1);

	apss_pkg::state_t state_q;
	apss_pkg::state_t state_d;

	logic                                                div_start;
	logic                                                div_done;
	logic [apss_pkg::DIV_LANES-1:0][DW-1:0]              div_opnd;
	logic [apss_pkg::DIV_LANES-1:0][DW-1:0]              div_quot;
	logic                                                page_en;
	apss_pkg::page_res_t                                 page_res;

	logic [RW-1:0]                w_in;
	logic [RW-1:0]                h_in;
	logic [RW-1:0]                xs_q;
	logic [RW-1:0]                ys_q;
	logic [RW-1:0]                ws_q;
	logic [RW-1:0]                hs_q;
	logic [DW-1:0]                qa_q;
	logic [DW-1:0]                qb_q;
	logic [DW-1:0]                qc_q;
	logic [DW-1:0]                qd_q;
	logic [apss_pkg::LVL_W-1:0]   lvl_q;
	logic [AXW-1:0]               axis_q;
	logic [CLW-1:0]               base_q;
	logic [2*AXW-1:0]             axis_sq;
	logic                         fit;
	logic [MW-1:0]                apx;
	logic [MW-1:0]                bpy;
	logic [SXW-1:0]               sx_q;
	logic [SXW-1:0]               sy_q;
	logic [NW-1:0]                nx_q;
	logic [NW-1:0]                ny_q;
	logic [CWW-1:0]               cw_full;
	logic [CWW-1:0]               ch_full;
	logic [RW-1:0]                sw0;
	logic [RW-1:0]                sh0;
	logic [RW:0]                  sumw;
	logic [RW:0]                  sumh;
	logic [RW:0]                  clipw;
	logic [RW:0]                  cliph;
	logic [NW-1:0]                i_q;
	logic [NW-1:0]                j_q;
	logic [DW-1:0]                pc;
	logic [DW-1:0]                pr;
	logic                         last_page;

	logic                               status_q;
	logic [apss_pkg::LVL_W-1:0]         mip_q;
	logic [apss_pkg::COL_W-1:0]         col_q;
	logic [apss_pkg::COL_W-1:0]         row_q;
	logic [apss_pkg::SHARD_W-1:0]       shard_q;
	logic [CLW-1:0]                     cell_q;
	logic                               inside_q;
	logic [apss_pkg::CROPWH_W-1:0]      cw_q;
	logic [apss_pkg::CROPWH_W-1:0]      ch_q;
	logic                               last_q;

	// A zero size counts as one pixel.
	assign w_in = (rect_w == '0) ? RW'(1) : rect_w;
	assign h_in = (rect_h == '0) ? RW'(1) : rect_h;

	assign div_opnd[apss_pkg::LANE_X0] = DW'(rect_x);
	assign div_opnd[apss_pkg::LANE_Y0] = DW'(rect_y);
	assign div_opnd[apss_pkg::LANE_X1] = DW'(rect_x) + DW'(w_in) - DW'(1);
	assign div_opnd[apss_pkg::LANE_Y1] = DW'(rect_y) + DW'(h_in) - DW'(1);

	apss_div #(
		.PAGE_PIXELS(PAGE_PIXELS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.opnd   (div_opnd),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Page indices at level L are the level-0 quotients shifted right by L,
	// so each search step only shifts and compares.
	assign fit = ((qc_q - qa_q) < DW'(PAGES_PER_AXIS_BUDGET)) &&
		((qd_q - qb_q) < DW'(PAGES_PER_AXIS_BUDGET));
	assign axis_sq = (2*AXW)'(axis_q) * (2*AXW)'(axis_q);

	// Offset into the first page is (x >> L) minus the page origin at that level.
	assign apx = MW'(qa_q) * MW'(PAGE_PIXELS);
	assign bpy = MW'(qb_q) * MW'(PAGE_PIXELS);

	assign cw_full = CWW'(nx_q) * CWW'(PAGE_PIXELS);
	assign ch_full = CWW'(ny_q) * CWW'(PAGE_PIXELS);
	assign sw0     = (ws_q == '0) ? RW'(1) : ws_q;
	assign sh0     = (hs_q == '0) ? RW'(1) : hs_q;
	assign sumw    = (RW+1)'(sx_q) + (RW+1)'(sw0);
	assign sumh    = (RW+1)'(sy_q) + (RW+1)'(sh0);
	assign clipw   = (sumw > (RW+1)'(cw_full)) ? (RW+1)'(cw_full) - (RW+1)'(sx_q)
		: (RW+1)'(sw0);
	assign cliph   = (sumh > (RW+1)'(ch_full)) ? (RW+1)'(ch_full) - (RW+1)'(sy_q)
		: (RW+1)'(sh0);

	assign pc        = qa_q + DW'(i_q);
	assign pr        = qb_q + DW'(j_q);
	assign last_page = (i_q == nx_q - NW'(1)) && (j_q == ny_q - NW'(1));

	apss_page #(
		.AXW(AXW)
	) u_page (
		.clk  (clk),
		.en   (page_en),
		.pc   (pc),
		.pr   (pr),
		.axis (axis_q),
		.base (base_q),
		.res  (page_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		page_en   = 1'b0;
		unique case (state_q)
			apss_pkg::ST_IDLE: begin
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = apss_pkg::ST_DIV;
				end
			end
			apss_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = apss_pkg::ST_SEARCH;
				end
			end
			apss_pkg::ST_SEARCH: begin
				if (fit) begin
					state_d = apss_pkg::ST_CROP;
				end else if (lvl_q == LAST_LVL) begin
					state_d = apss_pkg::ST_OUT;
				end
			end
			apss_pkg::ST_CROP: state_d = apss_pkg::ST_CLIP;
			apss_pkg::ST_CLIP: state_d = apss_pkg::ST_PAGE;
			apss_pkg::ST_PAGE: begin
				page_en = 1'b1;
				state_d = apss_pkg::ST_LOAD;
			end
			apss_pkg::ST_LOAD: state_d = apss_pkg::ST_OUT;
			apss_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = last_q ? apss_pkg::ST_IDLE : apss_pkg::ST_PAGE;
				end
			end
			default: state_d = apss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			apss_pkg::ST_IDLE: begin
				if (in_valid) begin
					xs_q <= rect_x;
					ys_q <= rect_y;
					ws_q <= w_in;
					hs_q <= h_in;
				end
			end
			apss_pkg::ST_DIV: begin
				if (div_done) begin
					qa_q   <= div_quot[apss_pkg::LANE_X0];
					qb_q   <= div_quot[apss_pkg::LANE_Y0];
					qc_q   <= div_quot[apss_pkg::LANE_X1];
					qd_q   <= div_quot[apss_pkg::LANE_Y1];
					lvl_q  <= '0;
					axis_q <= AXW'(SHARD_SIDE_PAGES);
					base_q <= '0;
				end
			end
			apss_pkg::ST_SEARCH: begin
				if (!fit && lvl_q == LAST_LVL) begin
					status_q <= 1'b1;
					mip_q    <= '0;
					col_q    <= '0;
					row_q    <= '0;
					shard_q  <= '0;
					cell_q   <= '0;
					inside_q <= 1'b0;
					sx_q     <= '0;
					sy_q     <= '0;
					cw_q     <= '0;
					ch_q     <= '0;
					last_q   <= 1'b1;
				end else if (!fit) begin
					qa_q   <= qa_q >> 1;
					qb_q   <= qb_q >> 1;
					qc_q   <= qc_q >> 1;
					qd_q   <= qd_q >> 1;
					xs_q   <= xs_q >> 1;
					ys_q   <= ys_q >> 1;
					ws_q   <= ws_q >> 1;
					hs_q   <= hs_q >> 1;
					lvl_q  <= lvl_q + apss_pkg::LVL_W'(1);
					axis_q <= axis_q >> 1;
					base_q <= base_q + CLW'(axis_sq);
				end
			end
			apss_pkg::ST_CROP: begin
				sx_q <= SXW'(MW'(xs_q) - apx);
				sy_q <= SXW'(MW'(ys_q) - bpy);
				nx_q <= NW'(qc_q - qa_q) + NW'(1);
				ny_q <= NW'(qd_q - qb_q) + NW'(1);
			end
			apss_pkg::ST_CLIP: begin
				cw_q <= apss_pkg::CROPWH_W'(clipw);
				ch_q <= apss_pkg::CROPWH_W'(cliph);
				i_q  <= '0;
				j_q  <= '0;
			end
			apss_pkg::ST_PAGE: begin
			end
			apss_pkg::ST_LOAD: begin
				status_q <= 1'b0;
				mip_q    <= lvl_q;
				col_q    <= apss_pkg::COL_W'(pc);
				row_q    <= apss_pkg::COL_W'(pr);
				shard_q  <= page_res.shard;
				cell_q   <= page_res.cell_idx;
				inside_q <= page_res.in_grid;
				last_q   <= last_page;
			end
			apss_pkg::ST_OUT: begin
				if (out_ready && !last_q) begin
					if (i_q == nx_q - NW'(1)) begin
						i_q <= '0;
						j_q <= j_q + NW'(1);
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == apss_pkg::ST_IDLE);
	assign out_valid   = (state_q == apss_pkg::ST_OUT);
	assign status      = status_q;
	assign mip_level   = mip_q;
	assign page_col    = col_q;
	assign page_row    = row_q;
	assign shard_num   = shard_q;
	assign cell_index  = cell_q;
	assign page_inside = inside_q;
	assign crop_x      = apss_pkg::CROPXY_W'(sx_q);
	assign crop_y      = apss_pkg::CROPXY_W'(sy_q);
	assign crop_w      = cw_q;
	assign crop_h      = ch_q;
	assign last        = last_q;

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == apss_pkg::ST_DIV))
		else $error("accepted rectangle did not start the divider");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == apss_pkg::ST_DIV))
		else $error("divider finished outside its state");

	a_nofit_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (last && !page_inside && mip_level == '0))
		else $error("no-fit beat is malformed");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !page_inside) |-> (shard_num == '0 && cell_index == '0))
		else $error("page outside the grid carries a shard or cell");

	a_inside_shard: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && page_inside) |-> (shard_num != '0 && !status))
		else $error("page inside the grid has no shard");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic                          status;
		logic [apss_pkg::LVL_W-1:0]    mip_level;
		logic [apss_pkg::COL_W-1:0]    page_col;
		logic [apss_pkg::COL_W-1:0]    page_row;
		logic [apss_pkg::SHARD_W-1:0]  shard_num;
		logic [apss_pkg::CELL_W-1:0]   cell_index;
		logic                          page_inside;
		logic [apss_pkg::CROPXY_W-1:0] crop_x;
		logic [apss_pkg::CROPXY_W-1:0] crop_y;
		logic [apss_pkg::CROPWH_W-1:0] crop_w;
		logic [apss_pkg::CROPWH_W-1:0] crop_h;
		logic                          last;
	} page_beat_t;

	typedef struct packed {
		logic [apss_pkg::RECT_W-1:0] x;
		logic [apss_pkg::RECT_W-1:0] y;
		logic [apss_pkg::RECT_W-1:0] w;
		logic [apss_pkg::RECT_W-1:0] h;
		logic                        typed;
		page_beat_t                  want;
	} rect_row_t;

	localparam page_beat_t NO_FIT = '{status: 1'b1, last: 1'b1, default: '0};
	localparam page_beat_t ORIGIN_PAGE = '{shard_num: 5'd1, page_inside: 1'b1,
		crop_w: 8'd1, crop_h: 8'd1, last: 1'b1, default: '0};
	localparam page_beat_t NONE = '0;

	localparam int RECT_ROWS    = 19;
	localparam int RANDOM_RECTS = 411;
	localparam int CALM_RECTS   = 40;
	localparam int RECT_MAX     = (1 << apss_pkg::RECT_W) - 1;

	// Directed rectangles: corners of the atlas, page seams, the top levels, zero sizes
	// and rectangles no level can hold.
	rect_row_t rect_table [RECT_ROWS] = '{
		'{18'd0,      18'd0,      18'd1,      18'd1,      1'b1, ORIGIN_PAGE},
		'{18'd0,      18'd0,      18'd0,      18'd0,      1'b1, ORIGIN_PAGE},
		'{18'd0,      18'd0,      18'd240,    18'd240,    1'b0, NONE},
		'{18'd119,    18'd119,    18'd2,      18'd2,      1'b0, NONE},
		'{18'd120,    18'd0,      18'd120,    18'd1,      1'b0, NONE},
		'{18'd0,      18'd0,      18'd241,    18'd1,      1'b0, NONE},
		'{18'd100,    18'd0,      18'd300,    18'd1,      1'b0, NONE},
		'{18'd245759, 18'd245759, 18'd1,      18'd1,      1'b0, NONE},
		'{18'd245760, 18'd0,      18'd1,      18'd1,      1'b0, NONE},
		'{18'd262143, 18'd262143, 18'd1,      18'd1,      1'b0, NONE},
		'{18'd0,      18'd0,      18'd122880, 18'd122880, 1'b0, NONE},
		'{18'd184320, 18'd184320, 18'd61440,  18'd61440,  1'b0, NONE},
		'{18'd245000, 18'd0,      18'd40000,  18'd1,      1'b0, NONE},
		'{18'd0,      18'd0,      18'd131072, 18'd1,      1'b1, NO_FIT},
		'{18'd0,      18'd0,      18'd262143, 18'd262143, 1'b1, NO_FIT},
		'{18'd262143, 18'd262143, 18'd262143, 18'd262143, 1'b1, NO_FIT},
		'{18'd100,    18'd200,    18'd0,      18'd5,      1'b0, NONE},
		'{18'd174762, 18'd87381,  18'd21845,  18'd43690,  1'b0, NONE},
		'{18'd87381,  18'd174762, 18'd0,      18'd0,      1'b0, NONE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [apss_pkg::RECT_W-1:0] rect_x = '0;
	logic [apss_pkg::RECT_W-1:0] rect_y = '0;
	logic [apss_pkg::RECT_W-1:0] rect_w = '0;
	logic [apss_pkg::RECT_W-1:0] rect_h = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [apss_pkg::LVL_W-1:0] mip_level;
	logic [apss_pkg::COL_W-1:0] page_col;
	logic [apss_pkg::COL_W-1:0] page_row;
	logic [apss_pkg::SHARD_W-1:0] shard_num;
	logic [apss_pkg::CELL_W-1:0] cell_index;
	logic page_inside;
	logic [apss_pkg::CROPXY_W-1:0] crop_x;
	logic [apss_pkg::CROPXY_W-1:0] crop_y;
	logic [apss_pkg::CROPWH_W-1:0] crop_w;
	logic [apss_pkg::CROPWH_W-1:0] crop_h;
	logic last;

	page_beat_t pending_pages [$];
	int mismatches = 0;
	bit calm = 1'b0;
	int rx_hold = 0;

	atlas_page_span_select_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.mip_level  (mip_level),
		.page_col   (page_col),
		.page_row   (page_row),
		.shard_num  (shard_num),
		.cell_index (cell_index),
		.page_inside(page_inside),
		.crop_x     (crop_x),
		.crop_y     (crop_y),
		.crop_w     (crop_w),
		.crop_h     (crop_h),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the page beats of one rectangle and queues them in order.
	function automatic void predict_span(input logic [apss_pkg::RECT_W-1:0] x_in, y_in,
			w_in, h_in);
		longint unsigned x, y, w, h, span, a, b, c, d;
		longint unsigned px0, py0, nx, ny, axis, base, sx, sy, sw, sh, cw, ch, pc, pr;
		int unsigned lv, lvl, i, j;
		bit hit;
		page_beat_t beat;
		x = 64'(x_in);
		y = 64'(y_in);
		w = (w_in == '0) ? 64'd1 : 64'(w_in);
		h = (h_in == '0) ? 64'd1 : 64'(h_in);
		hit = 1'b0;
		lvl = 0;
		px0 = 0;
		py0 = 0;
		nx = 0;
		ny = 0;
		span = 0;
		for (lv = 0; lv < apss_pkg::LEVEL_COUNT && !hit; lv++) begin
			span = 64'(apss_pkg::PAGE_PIXELS) << lv;
			a = x / span;
			b = y / span;
			c = (x + w - 1) / span;
			d = (y + h - 1) / span;
			if (c - a + 1 <= apss_pkg::PAGES_PER_AXIS_BUDGET &&
					d - b + 1 <= apss_pkg::PAGES_PER_AXIS_BUDGET) begin
				hit = 1'b1;
				lvl = lv;
				px0 = a;
				py0 = b;
				nx = c - a + 1;
				ny = d - b + 1;
			end
		end
		if (!hit) begin
			pending_pages.push_back(NO_FIT);
			return;
		end
		axis = 64'(apss_pkg::SHARD_SIDE_PAGES) >> lvl;
		base = 0;
		for (lv = 0; lv < lvl; lv++)
			base += (64'(apss_pkg::SHARD_SIDE_PAGES) >> lv) *
				(64'(apss_pkg::SHARD_SIDE_PAGES) >> lv);
		// The crop window is the same on every page of the span.
		sx = (x - px0 * span) >> lvl;
		sy = (y - py0 * span) >> lvl;
		sw = w >> lvl;
		sh = h >> lvl;
		if (sw == 0) sw = 1;
		if (sh == 0) sh = 1;
		cw = nx * 64'(apss_pkg::PAGE_PIXELS);
		ch = ny * 64'(apss_pkg::PAGE_PIXELS);
		if (sx + sw > cw) sw = cw - sx;
		if (sy + sh > ch) sh = ch - sy;
		for (j = 0; j < ny; j++) begin
			for (i = 0; i < nx; i++) begin
				pc = px0 + i;
				pr = py0 + j;
				beat = '0;
				beat.mip_level = lvl[apss_pkg::LVL_W-1:0];
				beat.page_col = pc[apss_pkg::COL_W-1:0];
				beat.page_row = pr[apss_pkg::COL_W-1:0];
				if (axis != 0 && pc < axis * 4 && pr < axis * 4) begin
					beat.shard_num = apss_pkg::SHARD_W'(1 + pc / axis + 4 * (pr / axis));
					beat.cell_index = apss_pkg::CELL_W'(base + (pr % axis) * axis +
						(pc % axis));
					beat.page_inside = 1'b1;
				end
				beat.crop_x = sx[apss_pkg::CROPXY_W-1:0];
				beat.crop_y = sy[apss_pkg::CROPXY_W-1:0];
				beat.crop_w = sw[apss_pkg::CROPWH_W-1:0];
				beat.crop_h = sh[apss_pkg::CROPWH_W-1:0];
				beat.last = (j == ny - 1 && i == nx - 1);
				pending_pages.push_back(beat);
			end
		end
	endfunction

	function automatic void check_field(input string name, input longint unsigned want, got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Drives one rectangle beat, holds it until taken, then records what it should produce.
	task automatic send_rect(input logic [apss_pkg::RECT_W-1:0] x, y, w, h,
			input logic typed, input page_beat_t want);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rect_x <= x;
		rect_y <= y;
		rect_w <= w;
		rect_h <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (typed)
			pending_pages.push_back(want);
		else
			predict_span(x, y, w, h);
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (arst_n && !calm && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			rx_hold <= $urandom_range(0, 17);
		end else begin
			out_ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		page_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pages.size() == 0) begin
				$display("%0t: page beat with none pending, actual status %0d level %0d col %0d row %0d",
					$time, status, mip_level, page_col, page_row);
				mismatches++;
			end else begin
				want = pending_pages.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("mip_level", 64'(want.mip_level), 64'(mip_level));
				check_field("page_col", 64'(want.page_col), 64'(page_col));
				check_field("page_row", 64'(want.page_row), 64'(page_row));
				check_field("shard_num", 64'(want.shard_num), 64'(shard_num));
				check_field("cell_index", 64'(want.cell_index), 64'(cell_index));
				check_field("page_inside", 64'(want.page_inside), 64'(page_inside));
				check_field("crop_x", 64'(want.crop_x), 64'(crop_x));
				check_field("crop_y", 64'(want.crop_y), 64'(crop_y));
				check_field("crop_w", 64'(want.crop_w), 64'(crop_w));
				check_field("crop_h", 64'(want.crop_h), 64'(crop_h));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	initial begin
		int n, sel;
		int unsigned lv, span;
		logic [apss_pkg::RECT_W-1:0] x, y, w, h;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (n = 0; n < RECT_ROWS; n++)
			send_rect(rect_table[n].x, rect_table[n].y, rect_table[n].w, rect_table[n].h,
				rect_table[n].typed, rect_table[n].want);
		for (n = 0; n < RANDOM_RECTS; n++) begin
			// Now and then the sender holds off until the block has drained.
			if (n % 100 == 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_pages.size() != 0) @(posedge clk);
			end
			calm = (n >= RANDOM_RECTS - CALM_RECTS);
			sel = $urandom_range(0, 99);
			lv = $urandom_range(0, apss_pkg::LEVEL_COUNT - 1);
			span = apss_pkg::PAGE_PIXELS << lv;
			if (sel < 60) begin
				// Sized for a chosen level so every level gets picked.
				x = apss_pkg::RECT_W'($urandom_range(0, 245759));
				y = apss_pkg::RECT_W'($urandom_range(0, 245759));
				w = apss_pkg::RECT_W'($urandom_range(1, 2 * span));
				h = apss_pkg::RECT_W'($urandom_range(1, 2 * span));
			end else if (sel < 72) begin
				x = apss_pkg::RECT_W'($urandom_range(0, RECT_MAX));
				y = apss_pkg::RECT_W'($urandom_range(0, RECT_MAX));
				w = apss_pkg::RECT_W'($urandom_range(0, 3));
				h = apss_pkg::RECT_W'($urandom_range(0, 3));
			end else if (sel < 85) begin
				// Near the far edges, where pages fall outside the shard grid.
				x = apss_pkg::RECT_W'($urandom_range(235000, RECT_MAX));
				y = apss_pkg::RECT_W'($urandom_range(0, RECT_MAX));
				w = apss_pkg::RECT_W'($urandom_range(1, 2 * span));
				h = apss_pkg::RECT_W'($urandom_range(1, 2 * span));
				if (sel[0]) begin
					x = y;
					y = apss_pkg::RECT_W'($urandom_range(235000, RECT_MAX));
				end
			end else begin
				x = apss_pkg::RECT_W'($urandom);
				y = apss_pkg::RECT_W'($urandom);
				w = apss_pkg::RECT_W'($urandom);
				h = apss_pkg::RECT_W'($urandom);
			end
			send_rect(x, y, w, h, 1'b0, NONE);
		end
		in_valid <= 1'b0;
		while (pending_pages.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_pages.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
